[hw/rtl/smsad_pkg.sv]
// Shared types, constants and the nibble-to-character function for the
// SMS address field decoder. No dependencies.
package smsad_pkg;

  typedef enum logic [1:0] {
    PH_LENGTH = 2'd0,
    PH_TYPE   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_ALPHA  = 2'd3
  } phase_t;

  localparam logic [2:0] TON_INTERNATIONAL = 3'd1;
  localparam logic [2:0] TON_ALPHANUMERIC  = 3'd5;

  localparam logic [3:0] NIB_STAR  = 4'hA;
  localparam logic [3:0] NIB_HASH  = 4'hB;
  localparam logic [3:0] NIB_PAUSE = 4'hC;
  localparam logic [3:0] NIB_END   = 4'hF;

  localparam logic [6:0] CH_STAR  = 7'h2A;
  localparam logic [6:0] CH_HASH  = 7'h23;
  localparam logic [6:0] CH_PAUSE = 7'h50;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_ZERO  = 7'h30;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] bytes_left;
    logic [2:0] saved_type;
    logic [3:0] saved_plan;
    logic       digits_ended;
  } dec_state_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       has_char;
    logic [2:0] number_type;
    logic [3:0] numbering_plan;
    logic       last;
  } result_t;

  function automatic logic [6:0] nibble_char(input logic [3:0] nib);
    logic [6:0] ch;
    case (nib)
      NIB_STAR:  ch = CH_STAR;
      NIB_HASH:  ch = CH_HASH;
      NIB_PAUSE: ch = CH_PAUSE;
      default:   ch = CH_ZERO + {3'b000, nib};
    endcase
    return ch;
  endfunction

endpackage

[hw/rtl/smsad_decode.sv]
// Combinational decode of one address-field byte: next parse state and
// up to two result items. Depends on smsad_pkg.
module smsad_decode
  import smsad_pkg::*;
(
  input  dec_state_t st,
  input  logic [7:0] data_byte,
  input  logic       start_field,
  output dec_state_t st_next,
  output logic [1:0] n_res,
  output result_t    res0,
  output result_t    res1
);

  phase_t     ph;
  logic [3:0] lo;
  logic [3:0] hi;
  logic       final_byte;
  logic [7:0] left_dec;
  logic [2:0] typ;

  assign ph         = start_field ? PH_LENGTH : st.phase;
  assign lo         = data_byte[3:0];
  assign hi         = data_byte[7:4];
  assign final_byte = (st.bytes_left <= 8'd1);
  assign left_dec   = (st.bytes_left == 8'd0) ? 8'd0 : st.bytes_left - 8'd1;
  assign typ        = data_byte[6:4];

  // next state
  always_comb begin
    st_next = st;
    st_next.phase = ph;
    case (ph)
      PH_LENGTH: begin
        st_next.bytes_left   = 8'((9'(data_byte) + 9'd1) >> 1);
        st_next.digits_ended = 1'b0;
        st_next.phase        = PH_TYPE;
      end
      PH_TYPE: begin
        st_next.saved_type = typ;
        st_next.saved_plan = lo;
        if (st.bytes_left == 8'd0) begin
          st_next.phase = PH_LENGTH;
        end else if (typ == TON_ALPHANUMERIC) begin
          st_next.phase = PH_ALPHA;
        end else begin
          st_next.phase = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        st_next.bytes_left = left_dec;
        if (!st.digits_ended && hi == NIB_END) begin
          st_next.digits_ended = 1'b1;
        end
        if (final_byte) begin
          st_next.phase = PH_LENGTH;
        end
      end
      default: begin
        st_next.bytes_left = left_dec;
        if (final_byte) begin
          st_next.phase = PH_LENGTH;
        end
      end
    endcase
  end

  // result items
  always_comb begin
    n_res = 2'd0;
    res0  = '0;
    res1  = '0;
    res0.number_type    = st_next.saved_type;
    res0.numbering_plan = st_next.saved_plan;
    res1.number_type    = st_next.saved_type;
    res1.numbering_plan = st_next.saved_plan;
    case (ph)
      PH_TYPE: begin
        if (st.bytes_left == 8'd0) begin
          n_res     = 2'd1;
          res0.last = 1'b1;
        end else if (typ == TON_INTERNATIONAL) begin
          n_res         = 2'd1;
          res0.char_code = CH_PLUS;
          res0.has_char = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (!st.digits_ended) begin
          res0.char_code = nibble_char(lo);
          res0.has_char  = 1'b1;
          if (hi == NIB_END) begin
            n_res     = 2'd1;
            res0.last = final_byte;
          end else begin
            n_res          = 2'd2;
            res1.char_code = nibble_char(hi);
            res1.has_char  = 1'b1;
            res1.last      = final_byte;
          end
        end else if (final_byte) begin
          n_res     = 2'd1;
          res0.last = 1'b1;
        end
      end
      PH_ALPHA: begin
        if (final_byte) begin
          n_res     = 2'd1;
          res0.last = 1'b1;
        end
      end
      default: begin
        n_res = 2'd0;
      end
    endcase
  end

endmodule

[hw/rtl/sms_address_field_decoder_unit.sv]
// Top level of the SMS address field decoder: input register, parse state,
// four-entry result queue. Depends on smsad_pkg and smsad_decode.
//
// Usage: feed the bytes of a GSM address field on the s_ channel, one item
// per byte: length, type byte, then packed semi-octet digits. s_tuser set
// on an item forces it to be taken as a new length byte, dropping any field
// in progress. Characters come out on the m_ channel, one item each; tuser
// marks whether the item carries a character, tlast ends the field.
// An accepted item is held in the input register and decoded into the queue
// once the queue has room for two results; its first result is visible after that decode.
// Throughput: one byte per cycle when it yields at most one result and m_tready
// stays high; a digit byte with two characters puts two items on the single-wide
// m_ channel, so sustained digit decoding is limited by the output side.
// The queue keeps taking decoded items while m_tready is low until fewer
// than two slots remain free; then s_tready drops and nothing is lost.
// Reset (rst, synchronous) empties the queue and input register and returns
// the parser to expecting a length byte.
module sms_address_field_decoder_unit
  import smsad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] start_field
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [6:0] char_code, [9:7] number_type,
                                 // [13:10] numbering_plan, [15:14] zero
  output logic        m_tuser,   // [0] has_char
  output logic        m_tlast
);

  logic       in_vld;
  logic [7:0] in_byte;
  logic       in_start;

  dec_state_t st;
  dec_state_t st_next;
  logic [1:0] n_res;
  result_t    res0;
  result_t    res1;

  result_t    fifo [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;

  logic pop;
  logic consume;
  logic [2:0] count_after_pop;

  assign pop             = m_tvalid && m_tready;
  assign count_after_pop = count - {2'b00, pop};
  assign consume         = in_vld && (count_after_pop <= 3'd2);
  assign s_tready        = !in_vld || consume;

  smsad_decode u_decode (
    .st          (st),
    .data_byte   (in_byte),
    .start_field (in_start),
    .st_next     (st_next),
    .n_res       (n_res),
    .res0        (res0),
    .res1        (res1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase        <= PH_LENGTH;
      st.bytes_left   <= 8'd0;
      st.saved_type   <= 3'd0;
      st.saved_plan   <= 4'd0;
      st.digits_ended <= 1'b0;
    end else if (consume) begin
      st <= st_next;
    end
  end

  always_comb begin
    count_next = count_after_pop;
    if (consume) begin
      count_next = count_after_pop + {1'b0, n_res};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      count <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (consume) begin
        wr_ptr <= wr_ptr + n_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && n_res != 2'd0) begin
      fifo[wr_ptr] <= res0;
    end
    if (consume && n_res == 2'd2) begin
      fifo[wr_ptr + 2'd1] <= res1;
    end
  end

  result_t head;
  assign head     = fifo[rd_ptr];
  assign m_tvalid = (count != 3'd0);
  assign m_tdata  = {2'b00, head.numbering_plan, head.number_type, head.char_code};
  assign m_tuser  = head.has_char;
  assign m_tlast  = head.last;

endmodule

[hw/rtl/smsad_checker.sv]
// Port-level checks for the SMS address field decoder, bound to the top
// level. Depends only on the top level's ports.
module smsad_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("stalled result item changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result item shown right after reset");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata[6:0] == 7'd0))
    else $error("empty result item not a clean end marker");

endmodule

bind sms_address_field_decoder_unit smsad_checker u_smsad_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
